/* rtl/core/lz_window_token_decoder_defines.svh */
// Assertion macros used by the checker file of the token decoder.
`ifndef LZ_WINDOW_TOKEN_DECODER_DEFINES_SVH
`define LZ_WINDOW_TOKEN_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LZD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LZD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/lzd_pkg.sv */
// Shared types and constants of the LZ window token decoder.
package lzd_pkg;

   localparam int LEN_W     = 8;
   localparam int OFF_W     = 14;
   localparam int TOTAL_W   = 32;
   localparam int CNT_W     = 4;
   localparam int LANE_W    = 3;
   localparam int WORD_W    = 64;
   localparam int STATUS_W  = 3;
   localparam int STG_DEPTH = 256;

   // Header byte codes of the token format.
   localparam logic [7:0] HDR_SHORT_MIN = 8'h40;
   localparam logic [7:0] HDR_MED_MIN   = 8'h22;
   localparam logic [7:0] HDR_MED_MAX   = 8'h27;
   localparam logic [7:0] HDR_LONG      = 8'h20;
   localparam logic [7:0] HDR_LIT_MAX   = 8'h0F;
   localparam logic [7:0] HDR_END       = 8'h00;
   localparam logic [7:0] RSV_MASK      = 8'h03;
   localparam logic [7:0] MED_LEN_MASK  = 8'h07;
   localparam logic [7:0] LIT_BIAS      = 8'd3;

   // Status codes carried on result items.
   localparam logic [STATUS_W-1:0] STATUS_DATA     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TRUNC    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TRAIL    = 3'd4;

   typedef enum logic [3:0] {
      PH_HEAD,
      PH_SHORT1,
      PH_MED1,
      PH_MED2,
      PH_LONG1,
      PH_LONG2,
      PH_LONG3,
      PH_ZERO1,
      PH_LIT
   } parse_phase_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_MOD,
      SEQ_CHK_LEN,
      SEQ_CHK_LIT,
      SEQ_READ,
      SEQ_GAP,
      SEQ_COPY,
      SEQ_PUSH,
      SEQ_STATUS
   } seq_state_type;

   typedef struct packed {
      logic [WORD_W-1:0]   data_word;
      logic [CNT_W-1:0]    byte_count;
      logic                run_last;
      logic [STATUS_W-1:0] status;
   } rsp_item_type;

endpackage

/* rtl/core/lzd_req_if.sv */
// Input channel carrying one compressed byte per item.
interface lzd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* rtl/core/lzd_rsp_if.sv */
// Result channel carrying up to eight decoded bytes and a status per item.
interface lzd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lzd_pkg::WORD_W-1:0]       data_word;
   logic [lzd_pkg::CNT_W-1:0]        byte_count;
   logic                             run_last;
   logic [lzd_pkg::STATUS_W-1:0]     status;

   modport source (output valid, output data_word, output byte_count, output run_last,
                   output status, input ready);
   modport sink   (input valid, input data_word, input byte_count, input run_last,
                   input status, output ready);
endinterface

/* rtl/core/lzd_out_queue.sv */
// Two-entry result queue: an output register plus one skid entry.
module lzd_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lzd_pkg::rsp_item_type push_item,
   output logic                  space,
   lzd_rsp_if.source             rsp
);

   lzd_pkg::rsp_item_type head_ff, head_in;
   lzd_pkg::rsp_item_type pend_ff, pend_in;
   logic                  head_v_ff, head_v_in;
   logic                  pend_v_ff, pend_v_in;
   logic                  pop;

   assign pop   = head_v_ff && rsp.ready;
   assign space = !pend_v_ff;

   // Pop moves the skid entry forward; a push fills the first free slot.
   always_comb begin
      head_in   = head_ff;
      head_v_in = head_v_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      if (pop) begin
         if (pend_v_ff) begin
            head_in   = pend_ff;
            pend_v_in = 1'b0;
         end else begin
            head_v_in = 1'b0;
         end
      end
      if (push) begin
         if (!head_v_in) begin
            head_in   = push_item;
            head_v_in = 1'b1;
         end else begin
            pend_in   = push_item;
            pend_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         pend_v_ff <= pend_v_in;
      end
      head_ff <= head_in;
      pend_ff <= pend_in;
   end

   assign rsp.valid      = head_v_ff;
   assign rsp.data_word  = head_ff.data_word;
   assign rsp.byte_count = head_ff.byte_count;
   assign rsp.run_last   = head_ff.run_last;
   assign rsp.status     = head_ff.status;

endmodule

/* rtl/core/lz_window_token_decoder.sv */
// LZ77 token decoder with a byte-wide history ring and a byte-wide copy staging memory.
// Header and literal bytes are taken one per cycle while the sequencer is idle and the result
// queue has space; a literal's result is registered in the output queue. A match's final byte
// holds the input through offset reduction, staging and copy-out, on the single byte-wide read
// port of each memory. Reset is synchronous; the ring reads as zero through its fill position, so no clearing pass.
module lz_window_token_decoder #(
   parameter int WINDOW_BYTES     = 4096,
   parameter int BYTES_PER_RESULT = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   lzd_req_if.sink                      req_ch,
   lzd_rsp_if.source                    rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [lzd_pkg::TOTAL_W-1:0]  csr_wr_data
);

   localparam int AW    = $clog2(WINDOW_BYTES);
   localparam int OW    = lzd_pkg::OFF_W;
   localparam int LW    = lzd_pkg::LANE_W;
   localparam int TW    = lzd_pkg::TOTAL_W;
   localparam int WW    = lzd_pkg::WORD_W;
   localparam logic [AW-1:0] WPOS_LAST = AW'(WINDOW_BYTES - 1);
   localparam logic [OW:0]   WIN_SPAN  = (OW + 1)'(WINDOW_BYTES);
   localparam logic [LW-1:0] LANE_LAST = LW'(BYTES_PER_RESULT - 1);

   // Sequencer and parser state.
   lzd_pkg::seq_state_type   seq_ff, seq_in;
   lzd_pkg::parse_phase_type phase_ff, phase_in;
   logic [lzd_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [OW-1:0]                off_ff, off_in;
   logic [lzd_pkg::LEN_W-1:0]    lit_ff, lit_in;
   logic [TW-1:0]                total_ff, total_in;
   logic [TW-1:0]                limit_ff, limit_in;
   logic [AW-1:0]                wpos_ff, wpos_in;
   logic                         wrap_ff, wrap_in;
   logic                         ended_ff, ended_in;
   logic                         err_ff, err_in;
   logic                         last_ff, last_in;
   logic [lzd_pkg::STATUS_W-1:0] st_ff, st_in;
   logic [AW-1:0]                rd_ptr_ff, rd_ptr_in;
   logic [lzd_pkg::LEN_W-1:0]    idx_ff, idx_in;
   logic [LW-1:0]                lane_ff, lane_in;
   logic                         done_ff, done_in;
   logic [WW-1:0]                word_ff, word_in;
   logic [lzd_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   // Memory pipelines.
   logic [7:0]                ring_mem [WINDOW_BYTES];
   logic [7:0]                stg_mem [lzd_pkg::STG_DEPTH];
   logic [7:0]                ring_q_ff;
   logic                      ring_hit_ff;
   logic                      ring_rv_ff;
   logic [lzd_pkg::LEN_W-1:0] stg_wa_ff;
   logic [7:0]                stg_q_ff;
   logic                      stg_rv_ff;
   logic                      ring_we;
   logic [7:0]                ring_wd;

   // Item handshake, shared adder and result push.
   logic                         req_fire;
   logic [7:0]                   in_b;
   logic [lzd_pkg::LEN_W-1:0]    add_val;
   logic [TW:0]                  ovf_sum;
   logic                         ovf;
   logic [TW-1:0]                total_sum;
   logic                         lit_start;
   logic                         match_go;
   logic                         data_lit;
   logic [lzd_pkg::STATUS_W-1:0] acc_st;
   logic                         finish;
   logic                         restart;
   logic                         push;
   lzd_pkg::rsp_item_type        push_item;
   logic                         q_space;

   assign in_b         = req_ch.in_byte;
   assign req_ch.ready = (seq_ff == lzd_pkg::SEQ_IDLE) && q_space;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Capacity check operand: the literal count at a header, else the match length or reserve.
   always_comb begin
      add_val = '0;
      unique case (seq_ff)
         lzd_pkg::SEQ_IDLE: begin
            add_val = (phase_ff == lzd_pkg::PH_ZERO1) ? in_b : in_b + lzd_pkg::LIT_BIAS;
         end
         lzd_pkg::SEQ_CHK_LEN: add_val = len_ff;
         lzd_pkg::SEQ_CHK_LIT: add_val = lit_ff;
         default: add_val = '0;
      endcase
   end

   assign ovf_sum   = {1'b0, total_ff} + (TW + 1)'(add_val) + (TW + 1)'(1);
   assign ovf       = ovf_sum > {1'b0, limit_ff};
   assign total_sum = total_ff + TW'(add_val);
   assign limit_in  = csr_wr_en ? csr_wr_data : limit_ff;

   // Parser, match sequencer and ring write position.
   always_comb begin
      seq_in    = seq_ff;
      phase_in  = phase_ff;
      len_in    = len_ff;
      off_in    = off_ff;
      lit_in    = lit_ff;
      total_in  = total_ff;
      wpos_in   = wpos_ff;
      wrap_in   = wrap_ff;
      ended_in  = ended_ff;
      err_in    = err_ff;
      last_in   = last_ff;
      st_in     = st_ff;
      rd_ptr_in = rd_ptr_ff;
      idx_in    = idx_ff;
      lane_in   = lane_ff;
      done_in   = done_ff;
      word_in   = word_ff;
      cnt_in    = cnt_ff;
      acc_st    = lzd_pkg::STATUS_DATA;
      lit_start = 1'b0;
      match_go  = 1'b0;
      data_lit  = 1'b0;
      finish    = 1'b0;
      restart   = 1'b0;
      push      = 1'b0;
      push_item = '0;
      ring_we   = 1'b0;
      ring_wd   = in_b;

      unique case (seq_ff)
         lzd_pkg::SEQ_IDLE: begin
            if (req_fire) begin
               if (err_ff) begin
                  acc_st = lzd_pkg::STATUS_DATA;
               end else if (ended_ff) begin
                  acc_st = lzd_pkg::STATUS_TRAIL;
               end else begin
                  unique case (phase_ff) inside
                     lzd_pkg::PH_HEAD: begin
                        if (in_b >= lzd_pkg::HDR_SHORT_MIN) begin
                           len_in   = 8'(in_b[7:5]) + 8'd1;
                           off_in   = OW'(in_b[4:2]);
                           lit_in   = in_b & lzd_pkg::RSV_MASK;
                           phase_in = lzd_pkg::PH_SHORT1;
                        end else if (in_b inside {[lzd_pkg::HDR_MED_MIN:lzd_pkg::HDR_MED_MAX]})
                        begin
                           len_in   = (in_b & lzd_pkg::MED_LEN_MASK) + 8'd1;
                           phase_in = lzd_pkg::PH_MED1;
                        end else if (in_b == lzd_pkg::HDR_LONG) begin
                           phase_in = lzd_pkg::PH_LONG1;
                        end else if (in_b == lzd_pkg::HDR_END) begin
                           phase_in = lzd_pkg::PH_ZERO1;
                        end else if (in_b <= lzd_pkg::HDR_LIT_MAX) begin
                           lit_start = 1'b1;
                        end
                     end
                     lzd_pkg::PH_SHORT1: begin
                        off_in   = off_ff + (OW'(in_b) << 3);
                        match_go = 1'b1;
                     end
                     lzd_pkg::PH_MED1, lzd_pkg::PH_LONG2: begin
                        off_in   = OW'(in_b >> 2);
                        lit_in   = in_b & lzd_pkg::RSV_MASK;
                        phase_in = (phase_ff == lzd_pkg::PH_MED1) ? lzd_pkg::PH_MED2
                                                                   : lzd_pkg::PH_LONG3;
                     end
                     lzd_pkg::PH_MED2, lzd_pkg::PH_LONG3: begin
                        off_in   = off_ff + (OW'(in_b) << 6);
                        match_go = 1'b1;
                     end
                     lzd_pkg::PH_LONG1: begin
                        len_in   = in_b;
                        phase_in = lzd_pkg::PH_LONG2;
                     end
                     lzd_pkg::PH_ZERO1: begin
                        if (in_b == lzd_pkg::HDR_END) begin
                           ended_in = 1'b1;
                           phase_in = lzd_pkg::PH_HEAD;
                        end else begin
                           lit_start = 1'b1;
                        end
                     end
                     lzd_pkg::PH_LIT: begin
                        ring_we  = 1'b1;
                        data_lit = 1'b1;
                        if (lit_ff != '0) begin
                           lit_in = lit_ff - 8'd1;
                        end
                        if (lit_ff <= 8'd1) begin
                           phase_in = lzd_pkg::PH_HEAD;
                        end
                     end
                     default: phase_in = lzd_pkg::PH_HEAD;
                  endcase
                  // A literal run reserves its whole length at the header.
                  if (lit_start) begin
                     if (ovf) begin
                        acc_st = lzd_pkg::STATUS_OVERFLOW;
                     end else begin
                        total_in = total_sum;
                        lit_in   = add_val;
                        phase_in = lzd_pkg::PH_LIT;
                     end
                  end
               end

               // A completed match goes to the sequencer; everything else ends here.
               if (match_go) begin
                  seq_in  = lzd_pkg::SEQ_MOD;
                  last_in = req_ch.in_last;
               end else begin
                  if (acc_st != lzd_pkg::STATUS_DATA) begin
                     err_in = 1'b1;
                  end else if (req_ch.in_last && !err_ff) begin
                     acc_st = (phase_in == lzd_pkg::PH_HEAD) ? lzd_pkg::STATUS_OK
                                                             : lzd_pkg::STATUS_TRUNC;
                  end
                  push                 = data_lit || (acc_st != lzd_pkg::STATUS_DATA);
                  push_item.data_word  = data_lit ? WW'(in_b) : '0;
                  push_item.byte_count = data_lit ? lzd_pkg::CNT_W'(1) : '0;
                  push_item.run_last   = 1'b1;
                  push_item.status     = acc_st;
                  restart              = req_ch.in_last;
               end
            end
         end

         // Bring the absolute offset into the window.
         lzd_pkg::SEQ_MOD: begin
            if ({1'b0, off_ff} >= WIN_SPAN) begin
               off_in = off_ff - WIN_SPAN[OW-1:0];
            end else begin
               rd_ptr_in = off_ff[AW-1:0];
               seq_in    = lzd_pkg::SEQ_CHK_LEN;
            end
         end

         lzd_pkg::SEQ_CHK_LEN: begin
            if (ovf) begin
               st_in  = lzd_pkg::STATUS_OVERFLOW;
               seq_in = lzd_pkg::SEQ_STATUS;
            end else begin
               total_in = total_sum;
               seq_in   = lzd_pkg::SEQ_CHK_LIT;
            end
         end

         // Reserve literals are checked now so the status can ride on the last chunk.
         lzd_pkg::SEQ_CHK_LIT: begin
            st_in = lzd_pkg::STATUS_DATA;
            if (lit_ff != '0) begin
               if (ovf) begin
                  st_in = lzd_pkg::STATUS_OVERFLOW;
               end else begin
                  total_in = total_sum;
                  if (last_ff) begin
                     st_in = lzd_pkg::STATUS_TRUNC;
                  end
               end
            end else if (last_ff) begin
               st_in = lzd_pkg::STATUS_OK;
            end
            idx_in  = '0;
            lane_in = '0;
            done_in = 1'b0;
            if (len_ff != '0) begin
               seq_in = lzd_pkg::SEQ_READ;
            end else if (st_in != lzd_pkg::STATUS_DATA) begin
               seq_in = lzd_pkg::SEQ_STATUS;
            end else begin
               finish = 1'b1;
            end
         end

         // One ring read per cycle into the staging memory.
         lzd_pkg::SEQ_READ: begin
            idx_in    = idx_ff + 8'd1;
            rd_ptr_in = (rd_ptr_ff == WPOS_LAST) ? '0 : rd_ptr_ff + AW'(1);
            if (idx_ff == len_ff - 8'd1) begin
               idx_in = '0;
               seq_in = lzd_pkg::SEQ_GAP;
            end
         end

         lzd_pkg::SEQ_GAP: begin
            seq_in = lzd_pkg::SEQ_COPY;
         end

         // One staging read per cycle, up to one chunk.
         lzd_pkg::SEQ_COPY: begin
            idx_in  = idx_ff + 8'd1;
            lane_in = lane_ff + LW'(1);
            if (idx_ff == len_ff - 8'd1) begin
               done_in = 1'b1;
               lane_in = '0;
               seq_in  = lzd_pkg::SEQ_PUSH;
            end else if (lane_ff == LANE_LAST) begin
               lane_in = '0;
               seq_in  = lzd_pkg::SEQ_PUSH;
            end
         end

         lzd_pkg::SEQ_PUSH: begin
            if (!stg_rv_ff && q_space) begin
               push                 = 1'b1;
               push_item.data_word  = word_ff;
               push_item.byte_count = cnt_ff;
               push_item.run_last   = done_ff;
               push_item.status     = done_ff ? st_ff : lzd_pkg::STATUS_DATA;
               word_in              = '0;
               cnt_in               = '0;
               if (done_ff) begin
                  finish = 1'b1;
               end else begin
                  seq_in = lzd_pkg::SEQ_COPY;
               end
            end
         end

         lzd_pkg::SEQ_STATUS: begin
            if (q_space) begin
               push               = 1'b1;
               push_item.run_last = 1'b1;
               push_item.status   = st_ff;
               finish             = 1'b1;
            end
         end

         default: seq_in = lzd_pkg::SEQ_IDLE;
      endcase

      // Staged byte arrives: append it to the ring and pack it into the chunk.
      if (stg_rv_ff) begin
         ring_we = 1'b1;
         ring_wd = stg_q_ff;
         word_in = word_ff | (WW'(stg_q_ff) << {cnt_ff[LW-1:0], 3'b000});
         cnt_in  = cnt_ff + lzd_pkg::CNT_W'(1);
      end

      if (ring_we) begin
         wpos_in = (wpos_ff == WPOS_LAST) ? '0 : wpos_ff + AW'(1);
         if (wpos_ff == WPOS_LAST) begin
            wrap_in = 1'b1;
         end
      end

      // End of a match token.
      if (finish) begin
         seq_in = lzd_pkg::SEQ_IDLE;
         if (last_ff) begin
            restart = 1'b1;
         end else if (st_in == lzd_pkg::STATUS_OVERFLOW) begin
            err_in = 1'b1;
         end else begin
            phase_in = (lit_ff != '0) ? lzd_pkg::PH_LIT : lzd_pkg::PH_HEAD;
         end
      end

      // A stream end returns the parser and the ring fill position to their reset values.
      if (restart) begin
         phase_in = lzd_pkg::PH_HEAD;
         len_in   = '0;
         off_in   = '0;
         lit_in   = '0;
         total_in = '0;
         wpos_in  = '0;
         wrap_in  = 1'b0;
         ended_in = 1'b0;
         err_in   = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff     <= lzd_pkg::SEQ_IDLE;
         phase_ff   <= lzd_pkg::PH_HEAD;
         len_ff     <= '0;
         off_ff     <= '0;
         lit_ff     <= '0;
         total_ff   <= '0;
         limit_ff   <= '1;
         wpos_ff    <= '0;
         wrap_ff    <= 1'b0;
         ended_ff   <= 1'b0;
         err_ff     <= 1'b0;
         last_ff    <= 1'b0;
         st_ff      <= lzd_pkg::STATUS_DATA;
         rd_ptr_ff  <= '0;
         idx_ff     <= '0;
         lane_ff    <= '0;
         done_ff    <= 1'b0;
         word_ff    <= '0;
         cnt_ff     <= '0;
         ring_rv_ff <= 1'b0;
         stg_rv_ff  <= 1'b0;
      end else begin
         seq_ff     <= seq_in;
         phase_ff   <= phase_in;
         len_ff     <= len_in;
         off_ff     <= off_in;
         lit_ff     <= lit_in;
         total_ff   <= total_in;
         limit_ff   <= limit_in;
         wpos_ff    <= wpos_in;
         wrap_ff    <= wrap_in;
         ended_ff   <= ended_in;
         err_ff     <= err_in;
         last_ff    <= last_in;
         st_ff      <= st_in;
         rd_ptr_ff  <= rd_ptr_in;
         idx_ff     <= idx_in;
         lane_ff    <= lane_in;
         done_ff    <= done_in;
         word_ff    <= word_in;
         cnt_ff     <= cnt_in;
         ring_rv_ff <= (seq_ff == lzd_pkg::SEQ_READ);
         stg_rv_ff  <= (seq_ff == lzd_pkg::SEQ_COPY);
      end
   end

   // History ring: written at the fill position, read at the match pointer.
   // Entries at or past the fill position before the first wrap read as zero.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wpos_ff] <= ring_wd;
      end
      ring_q_ff   <= ring_mem[rd_ptr_ff];
      ring_hit_ff <= wrap_ff || (rd_ptr_ff < wpos_ff);
      stg_wa_ff   <= idx_ff;
   end

   // Copy staging: holds the whole match before any of it enters the ring.
   always_ff @(posedge clock) begin
      if (ring_rv_ff) begin
         stg_mem[stg_wa_ff] <= ring_hit_ff ? ring_q_ff : 8'd0;
      end
      stg_q_ff <= stg_mem[idx_ff];
   end

   lzd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .space     (q_space),
      .rsp       (rsp_ch)
   );

endmodule

/* rtl/core/lzd_checker.sv */
// Port-level checks of the token decoder's result channel, bound to the top level.
`include "lz_window_token_decoder_defines.svh"

module lzd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [lzd_pkg::WORD_W-1:0]         data_word,
   input logic [lzd_pkg::CNT_W-1:0]          byte_count,
   input logic                               run_last,
   input logic [lzd_pkg::STATUS_W-1:0]       status
);

   // A stalled result item holds its payload.
   `LZD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(data_word) && $stable(byte_count) && $stable(status), "result item changed while stalled")

   // An item without data exists only to carry a final status.
   `LZD_ASSERT_SAME(a_empty_is_status, clock, reset, rsp_valid && (byte_count == '0), (data_word == '0) && run_last && (status != lzd_pkg::STATUS_DATA), "empty result item without a final status")

   // A nonzero status always closes the results of its input item.
   `LZD_ASSERT_SAME(a_status_is_last, clock, reset, rsp_valid && (status != lzd_pkg::STATUS_DATA), run_last, "status on a result item that is not the last")

   // Nothing is offered right after reset.
   `LZD_ASSERT_SAME(a_quiet_after_reset, clock, reset, $past(reset), !rsp_valid, "result item offered right after reset")

endmodule

bind lz_window_token_decoder lzd_checker u_lzd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .data_word  (rsp_ch.data_word),
   .byte_count (rsp_ch.byte_count),
   .run_last   (rsp_ch.run_last),
   .status     (rsp_ch.status)
);

/* sim/testbench.sv */
// Self-checking testbench for the LZ window token decoder: random token streams and a predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 800;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_PCT      = 25;
   localparam int RING_BYTES    = 4096;
   localparam int WORD_BYTES    = 8;
   localparam int PRINT_CAP     = 200;
   localparam logic [7:0]  LIT_MIN   = 8'h01;
   localparam logic [7:0]  JUNK_MIN  = 8'h10;
   localparam logic [7:0]  JUNK_MAX  = 8'h3F;
   localparam logic [7:0]  JUNK_ALT  = 8'h21;
   localparam logic [31:0] LIMIT_MAX = 32'hFFFF_FFFF;
   localparam logic [31:0] LIMIT_MIN = 32'd1;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } comp_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [lzd_pkg::TOTAL_W-1:0] csr_wr_data;

   lzd_req_if req_if();
   lzd_rsp_if rsp_if();

   lz_window_token_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running clock.
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Shadow state of the decoder.
   logic [7:0]               hist_ring [0:RING_BYTES-1];
   logic [11:0]              wr_pos;
   logic [31:0]              out_total;
   lzd_pkg::parse_phase_type phase;
   logic [7:0]               tok_len;
   logic [13:0]              tok_off;
   logic [7:0]               lits_left;
   bit                       ended;
   bit                       errored;
   logic [31:0]              out_limit;

   lzd_pkg::rsp_item_type expected_words[$];
   comp_byte_type         pending_bytes[$];
   logic [7:0]            strm[$];
   int                    strm_pos;
   int                    items_queued = 0;
   int                    items_taken = 0;
   int                    mismatches = 0;
   bit                    req_taken = 1'b0;
   bit                    src_idle_on = 1'b1;
   bit                    sink_idle_on = 1'b1;
   int                    hold_mark = 32'h7FFF_FFFF;
   int                    hold_left = 0;
   bit                    hold_done = 1'b0;

   // Clears the shadow state at the end of a stream, or at reset.
   function automatic void clear_stream_state();
      int i;
      for (i = 0; i < RING_BYTES; i++) hist_ring[i] = 8'h00;
      wr_pos    = '0;
      out_total = '0;
      phase     = lzd_pkg::PH_HEAD;
      tok_len   = '0;
      tok_off   = '0;
      lits_left = '0;
      ended     = 1'b0;
      errored   = 1'b0;
   endfunction

   function automatic void ring_append(logic [7:0] b);
      hist_ring[wr_pos] = b;
      wr_pos = wr_pos + 12'd1;
   endfunction

   function automatic void queue_word(logic [63:0] w, int cnt);
      lzd_pkg::rsp_item_type item;
      item.data_word  = w;
      item.byte_count = lzd_pkg::CNT_W'(cnt);
      item.run_last   = 1'b0;
      item.status     = lzd_pkg::STATUS_DATA;
      expected_words.push_back(item);
   endfunction

   // True when adding this many bytes would break the output capacity.
   function automatic bit over_capacity(int unsigned add);
      return ({32'd0, out_total} + 64'(add) + 64'd1) > {32'd0, out_limit};
   endfunction

   // A match stages all of its window bytes before any of them lands in the ring.
   function automatic logic [lzd_pkg::STATUS_W-1:0] copy_match();
      logic [7:0]  staged [0:lzd_pkg::STG_DEPTH-1];
      logic [63:0] w;
      int          n, j, k, c;
      n = tok_len;
      if (over_capacity(n)) return lzd_pkg::STATUS_OVERFLOW;
      out_total = out_total + n;
      for (j = 0; j < n; j++) staged[j] = hist_ring[(int'(tok_off) + j) % RING_BYTES];
      for (j = 0; j < n; j++) ring_append(staged[j]);
      for (j = 0; j < n; j += WORD_BYTES) begin
         w = '0;
         c = 0;
         for (k = 0; k < WORD_BYTES && j + k < n; k++) begin
            w[8*k +: 8] = staged[j + k];
            c++;
         end
         queue_word(w, c);
      end
      if (lits_left != 0) begin
         if (over_capacity(lits_left)) return lzd_pkg::STATUS_OVERFLOW;
         out_total = out_total + lits_left;
         phase = lzd_pkg::PH_LIT;
      end else begin
         phase = lzd_pkg::PH_HEAD;
      end
      return lzd_pkg::STATUS_DATA;
   endfunction

   function automatic logic [lzd_pkg::STATUS_W-1:0] open_literal_run(int cnt);
      if (over_capacity(cnt)) return lzd_pkg::STATUS_OVERFLOW;
      out_total = out_total + cnt;
      lits_left = 8'(cnt);
      phase = lzd_pkg::PH_LIT;
      return lzd_pkg::STATUS_DATA;
   endfunction

   function automatic logic [lzd_pkg::STATUS_W-1:0] parse_token_byte(logic [7:0] b);
      case (phase)
         lzd_pkg::PH_HEAD: begin
            if (b >= lzd_pkg::HDR_SHORT_MIN) begin
               tok_len   = (b >> 5) + 8'd1;
               tok_off   = 14'((b >> 2) & 8'h07);
               lits_left = b & lzd_pkg::RSV_MASK;
               phase     = lzd_pkg::PH_SHORT1;
            end else if (b >= lzd_pkg::HDR_MED_MIN && b <= lzd_pkg::HDR_MED_MAX) begin
               tok_len = (b & lzd_pkg::MED_LEN_MASK) + 8'd1;
               phase   = lzd_pkg::PH_MED1;
            end else if (b == lzd_pkg::HDR_LONG) begin
               phase = lzd_pkg::PH_LONG1;
            end else if (b >= LIT_MIN && b <= lzd_pkg::HDR_LIT_MAX) begin
               return open_literal_run(int'(b) + int'(lzd_pkg::LIT_BIAS));
            end else if (b == lzd_pkg::HDR_END) begin
               phase = lzd_pkg::PH_ZERO1;
            end
            return lzd_pkg::STATUS_DATA;
         end
         lzd_pkg::PH_SHORT1: begin
            tok_off = tok_off + {3'd0, b, 3'd0};
            return copy_match();
         end
         lzd_pkg::PH_MED1, lzd_pkg::PH_LONG2: begin
            tok_off   = 14'(b >> 2);
            lits_left = b & lzd_pkg::RSV_MASK;
            phase     = (phase == lzd_pkg::PH_MED1) ? lzd_pkg::PH_MED2 : lzd_pkg::PH_LONG3;
            return lzd_pkg::STATUS_DATA;
         end
         lzd_pkg::PH_MED2, lzd_pkg::PH_LONG3: begin
            tok_off = tok_off + {b, 6'd0};
            return copy_match();
         end
         lzd_pkg::PH_LONG1: begin
            tok_len = b;
            phase   = lzd_pkg::PH_LONG2;
            return lzd_pkg::STATUS_DATA;
         end
         lzd_pkg::PH_ZERO1: begin
            if (b == lzd_pkg::HDR_END) begin
               ended = 1'b1;
               phase = lzd_pkg::PH_HEAD;
               return lzd_pkg::STATUS_DATA;
            end
            return open_literal_run(b);
         end
         lzd_pkg::PH_LIT: begin
            ring_append(b);
            queue_word({56'd0, b}, 1);
            if (lits_left > 0) lits_left = lits_left - 8'd1;
            if (lits_left == 0) phase = lzd_pkg::PH_HEAD;
            return lzd_pkg::STATUS_DATA;
         end
         default: begin
            phase = lzd_pkg::PH_HEAD;
            return lzd_pkg::STATUS_DATA;
         end
      endcase
   endfunction

   // Works out the results of one accepted item and queues them.
   function automatic void decode_step(logic [7:0] b, logic last);
      logic [lzd_pkg::STATUS_W-1:0] st;
      int                           first_new;
      first_new = expected_words.size();
      st = lzd_pkg::STATUS_DATA;
      if (!errored) begin
         if (ended) st = lzd_pkg::STATUS_TRAIL;
         else st = parse_token_byte(b);
         if (st != lzd_pkg::STATUS_DATA) errored = 1'b1;
         else if (last)
            st = (phase == lzd_pkg::PH_HEAD) ? lzd_pkg::STATUS_OK : lzd_pkg::STATUS_TRUNC;
         if (st != lzd_pkg::STATUS_DATA) begin
            if (expected_words.size() == first_new) queue_word('0, 0);
            expected_words[expected_words.size()-1].status = st;
         end
      end
      if (expected_words.size() > first_new)
         expected_words[expected_words.size()-1].run_last = 1'b1;
      if (last) clear_stream_state();
   endfunction

   task automatic report_mismatch(string what);
      if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_result(lzd_pkg::rsp_item_type got);
      lzd_pkg::rsp_item_type want;
      if (expected_words.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected: %h", got));
         return;
      end
      want = expected_words.pop_front();
      if (got.data_word !== want.data_word)
         report_mismatch($sformatf("data_word %h, expected %h", got.data_word, want.data_word));
      if (got.byte_count !== want.byte_count)
         report_mismatch($sformatf("byte_count %0d, expected %0d", got.byte_count,
                                   want.byte_count));
      if (got.run_last !== want.run_last)
         report_mismatch($sformatf("run_last %b, expected %b", got.run_last, want.run_last));
      if (got.status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
   endtask

   // Monitor: check results first, then predict from the accepted item.
   always @(posedge clock) begin
      lzd_pkg::rsp_item_type got;
      if (reset) begin
         clear_stream_state();
         out_limit = LIMIT_MAX;
         req_taken = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.data_word  = rsp_if.data_word;
            got.byte_count = rsp_if.byte_count;
            got.run_last   = rsp_if.run_last;
            got.status     = rsp_if.status;
            check_result(got);
         end
         if (req_if.valid && req_if.ready) begin
            decode_step(req_if.in_byte, req_if.in_last);
            items_taken++;
         end
         if (csr_wr_en) out_limit = csr_wr_data;
         req_taken = req_if.valid && req_if.ready;
      end
   end

   // Driver: offers the next pending item once the current one is taken.
   always @(negedge clock) begin
      comp_byte_type nxt;
      logic          v;
      logic [7:0]    b;
      logic          l;
      v = req_if.valid;
      b = req_if.in_byte;
      l = req_if.in_last;
      if (reset) begin
         v = 1'b0;
         b = '0;
         l = 1'b0;
      end else if (!v || req_taken) begin
         v = 1'b0;
         if (pending_bytes.size() > 0 && !(src_idle_on && $urandom_range(99) < IDLE_PCT)) begin
            nxt = pending_bytes.pop_front();
            v = 1'b1;
            b = nxt.data;
            l = nxt.last;
         end
      end
      req_if.valid   <= v;
      req_if.in_byte <= b;
      req_if.in_last <= l;
   end

   // Receiver: random stalls, plus one long hold-off while the sender keeps going.
   always @(negedge clock) begin
      logic rdy;
      if (reset) begin
         rdy = 1'b0;
      end else if (hold_left > 0) begin
         rdy = 1'b0;
         hold_left--;
      end else if (!hold_done && items_taken >= hold_mark) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rdy = 1'b0;
      end else begin
         rdy = !(sink_idle_on && $urandom_range(99) < IDLE_PCT);
      end
      rsp_if.ready <= rdy;
   end

   // Stream building.
   task automatic append_byte(int v);
      strm.push_back(8'(v));
   endtask

   task automatic send_stream();
      comp_byte_type item;
      int i;
      for (i = 0; i < strm.size(); i++) begin
         item.data = strm[i];
         item.last = (i == strm.size() - 1);
         pending_bytes.push_back(item);
      end
      items_queued += strm.size();
      strm.delete();
      strm_pos = 0;
   endtask

   // Offsets mostly point into bytes already decoded, sometimes right behind the write point.
   function automatic int pick_offset(int max_off);
      int off;
      if (strm_pos > 0 && $urandom_range(99) < 85) begin
         if ($urandom_range(3) == 0)
            off = strm_pos - 1 - int'($urandom_range((strm_pos - 1 < 7) ? strm_pos - 1 : 7));
         else
            off = $urandom_range(strm_pos - 1);
         return (off > max_off) ? max_off : off;
      end
      return $urandom_range(max_off);
   endfunction

   task automatic add_literal_run();
      int n;
      if ($urandom_range(1) == 1) begin
         n = $urandom_range(int'(lzd_pkg::HDR_LIT_MAX), int'(LIT_MIN));
         append_byte(n);
         n += lzd_pkg::LIT_BIAS;
      end else begin
         n = ($urandom_range(19) == 0) ? $urandom_range(255, 100) : $urandom_range(24, 1);
         append_byte(lzd_pkg::HDR_END);
         append_byte(n);
      end
      repeat (n) append_byte($urandom_range(255));
      strm_pos += n;
   endtask

   task automatic add_match();
      int len, off, rsv;
      rsv = ($urandom_range(1) == 1) ? 0 : $urandom_range(3);
      case ($urandom_range(2))
         0: begin
            len = $urandom_range(8, 3);
            off = pick_offset(2047);
            append_byte({3'(len - 1), 3'(off), 2'(rsv)});
            append_byte(off >> 3);
         end
         1: begin
            len = $urandom_range(8, 3);
            off = pick_offset(16383);
            append_byte(int'(lzd_pkg::HDR_MED_MIN) + len - 3);
            append_byte({6'(off), 2'(rsv)});
            append_byte(off >> 6);
         end
         default: begin
            len = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(20);
            off = pick_offset(16383);
            append_byte(lzd_pkg::HDR_LONG);
            append_byte(len);
            append_byte({6'(off), 2'(rsv)});
            append_byte(off >> 6);
         end
      endcase
      strm_pos += len + rsv;
      repeat (rsv) append_byte($urandom_range(255));
   endtask

   task automatic add_junk_header();
      logic [7:0] b;
      b = 8'($urandom_range(int'(JUNK_MAX), int'(JUNK_MIN)));
      if (b == lzd_pkg::HDR_LONG || (b >= lzd_pkg::HDR_MED_MIN && b <= lzd_pkg::HDR_MED_MAX))
         b = JUNK_ALT;
      append_byte(b);
   endtask

   // One stream: mostly well-formed tokens, with a random way of ending it.
   task automatic build_stream();
      int sel;
      repeat ($urandom_range(6, 1)) begin
         sel = $urandom_range(99);
         if (sel < 45) add_literal_run();
         else if (sel < 90) add_match();
         else add_junk_header();
      end
      sel = $urandom_range(9);
      if (sel <= 5) begin
         append_byte(lzd_pkg::HDR_END);
         append_byte(lzd_pkg::HDR_END);
      end else if (sel == 7) begin
         // Cut the stream inside a token.
         case ($urandom_range(3))
            0: begin
               append_byte(lzd_pkg::HDR_LONG);
               append_byte($urandom_range(255));
            end
            1: append_byte({3'($urandom_range(7, 2)), 5'($urandom_range(31))});
            2: append_byte(lzd_pkg::HDR_END);
            default: begin
               append_byte(8'h05);
               repeat ($urandom_range(7)) append_byte($urandom_range(255));
            end
         endcase
      end else if (sel == 8) begin
         append_byte(lzd_pkg::HDR_END);
         append_byte(lzd_pkg::HDR_END);
         repeat ($urandom_range(3, 1)) append_byte($urandom_range(255));
      end else if (sel == 9) begin
         repeat ($urandom_range(6, 1)) append_byte($urandom_range(255));
      end
      send_stream();
   endtask

   task automatic random_streams(int budget);
      int goal;
      goal = items_queued + budget;
      while (items_queued < goal) build_stream();
   endtask

   // Waits until every item is taken and every result has come, then lets the block settle.
   task automatic wait_idle();
      while (items_taken != items_queued || expected_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(logic [31:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Stimulus and end of run.
   initial begin
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      strm_pos       = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      write_limit(LIMIT_MAX);
      // Literals, then a short match that overlaps its own output, a literal and the marker.
      append_byte(LIT_MIN);
      append_byte(8'hFF); append_byte(8'h00); append_byte(8'h5A); append_byte(8'hA5);
      append_byte(8'hE1); append_byte(8'h00);
      append_byte(8'h77);
      append_byte(lzd_pkg::HDR_END); append_byte(lzd_pkg::HDR_END);
      send_stream();
      // Zero-prefixed run, medium match, empty long match at the top offset with
      // three literals, an unknown header, the marker and a trailing byte.
      append_byte(lzd_pkg::HDR_END); append_byte(8'h03);
      append_byte(8'h80); append_byte(8'h01); append_byte(8'hFE);
      append_byte(lzd_pkg::HDR_MED_MAX); append_byte(8'h04); append_byte(8'h00);
      append_byte(lzd_pkg::HDR_LONG); append_byte(8'h00); append_byte(8'hFF);
      append_byte(8'hFF);
      append_byte(8'h11); append_byte(8'h22); append_byte(8'h33);
      append_byte(JUNK_MAX);
      append_byte(lzd_pkg::HDR_END); append_byte(lzd_pkg::HDR_END);
      append_byte(8'h42);
      send_stream();
      // Stream cut inside a long match.
      append_byte(lzd_pkg::HDR_LONG); append_byte(8'h05);
      send_stream();
      wait_idle();

      // Smallest capacity: any token with bytes overflows.
      write_limit(LIMIT_MIN);
      append_byte(8'h05); append_byte(LIT_MIN); append_byte(8'h02);
      send_stream();
      append_byte(lzd_pkg::HDR_LONG); append_byte(8'h00); append_byte(8'h00);
      append_byte(8'h00);
      send_stream();
      append_byte(lzd_pkg::HDR_SHORT_MIN); append_byte(8'h00);
      send_stream();
      random_streams(10);
      wait_idle();

      // Overflow on the literals that follow a match, and on the count of a zero-prefixed run.
      write_limit(32'd12);
      append_byte(lzd_pkg::HDR_END); append_byte(8'h08);
      repeat (8) append_byte($urandom_range(255));
      append_byte(8'h42); append_byte(8'h00);
      append_byte(LIT_MIN);
      send_stream();
      append_byte(lzd_pkg::HDR_END); append_byte(8'h0C); append_byte(8'h00);
      send_stream();
      wait_idle();

      write_limit(32'($urandom_range(80, 16)));
      random_streams(20);
      wait_idle();

      // Bulk traffic at full capacity with one long hold-off of the receiver.
      write_limit(LIMIT_MAX);
      hold_mark = items_queued + 20;
      random_streams(60);
      wait_idle();

      // A stretch with no idling on either side.
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      write_limit(32'($urandom_range(400, 100)));
      random_streams(20);
      wait_idle();

      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lzd_pkg.sv
rtl/core/lzd_req_if.sv
rtl/core/lzd_rsp_if.sv
rtl/core/lzd_out_queue.sv
rtl/core/lz_window_token_decoder.sv
rtl/core/lzd_checker.sv
sim/testbench.sv
